### design/va3_pkg.sv
// Shared constants, types and helper functions for the 3D vector angle pipeline.
// No dependencies.
package va3_pkg;

  localparam int unsigned COMP_W_DEF   = 16;
  localparam int unsigned ANGLE_FB_DEF = 14;

  // squared lengths and dot product terms
  localparam int unsigned NW  = 64;
  localparam int unsigned NP  = NW / 2;
  localparam int unsigned LZW = $clog2(NP);
  // division numerator, quotient
  localparam int unsigned XW  = NW + 1;
  localparam int unsigned QW  = 31;
  // sine radicand
  localparam int unsigned RADW = 62;
  // CORDIC datapath
  localparam int unsigned CRW          = 34;
  localparam int unsigned CORDIC_STEPS = 31;

  localparam logic [QW-1:0]          Q30_ONE     = 31'h4000_0000;
  localparam logic [RADW-1:0]        Q60_ONE     = 62'h1000_0000_0000_0000;
  localparam logic signed [CRW-1:0]  HALF_PI_Q30 = 34'sh0_6487_ED51;
  localparam logic signed [CRW-1:0]  PI_Q30      = 34'sh0_C90F_DAA2;

  typedef struct packed {
    logic vld;
    logic deg;
    logic dneg;
  } side_t;

  // leading zero bit pairs, 0 when either of the top two bits is set
  function automatic logic [LZW-1:0] lz_pairs(input logic [NW-1:0] n);
    logic [LZW-1:0] cnt;
    logic           hit;
    cnt = LZW'(NP - 1);
    hit = 1'b0;
    for (int k = NP - 1; k >= 0; k--) begin
      if (!hit && n[2*k +: 2] != 2'b00) begin
        cnt = LZW'(NP - 1 - k);
        hit = 1'b1;
      end
    end
    return cnt;
  endfunction

  // atan(2^-i) in Q30
  function automatic logic signed [CRW-1:0] atan_q30(input int unsigned i);
    logic signed [CRW-1:0] v;
    case (i)
      0:       v = 34'sh0_3243_F6A8;
      1:       v = 34'sh0_1DAC_6705;
      2:       v = 34'sh0_0FAD_BAFC;
      3:       v = 34'sh0_07F5_6EA6;
      4:       v = 34'sh0_03FE_AB76;
      5:       v = 34'sh0_01FF_D55B;
      6:       v = 34'sh0_00FF_FAAA;
      7:       v = 34'sh0_007F_FF55;
      8:       v = 34'sh0_003F_FFEA;
      9:       v = 34'sh0_001F_FFFD;
      10:      v = 34'sh0_000F_FFFF;
      11:      v = 34'sh0_0007_FFFF;
      12:      v = 34'sh0_0003_FFFF;
      13:      v = 34'sh0_0001_FFFF;
      14:      v = 34'sh0_0000_FFFF;
      15:      v = 34'sh0_0000_7FFF;
      16:      v = 34'sh0_0000_3FFF;
      17:      v = 34'sh0_0000_1FFF;
      18:      v = 34'sh0_0000_0FFF;
      19:      v = 34'sh0_0000_07FF;
      20:      v = 34'sh0_0000_03FF;
      21:      v = 34'sh0_0000_01FF;
      22:      v = 34'sh0_0000_00FF;
      23:      v = 34'sh0_0000_007F;
      24:      v = 34'sh0_0000_003F;
      25:      v = 34'sh0_0000_001F;
      26:      v = 34'sh0_0000_000F;
      27:      v = 34'sh0_0000_0008;
      28:      v = 34'sh0_0000_0004;
      29:      v = 34'sh0_0000_0002;
      30:      v = 34'sh0_0000_0001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### design/va3_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// No package dependencies; instantiated by vector_angle_3d.
module va3_isqrt #(
  parameter int unsigned IN_W = 64
) (
  input  logic              clk_i,
  input  logic [IN_W-1:0]   rad_i,
  output logic [IN_W/2-1:0] root_o
);

  localparam int unsigned OW = IN_W / 2;
  localparam int unsigned RW = OW + 2;

  logic [RW-1:0]   rem_q  [OW];
  logic [OW-1:0]   root_q [OW];
  logic [IN_W-1:0] rad_q  [OW];

  for (genvar g = 0; g < OW; g++) begin : g_stage
    logic [RW-1:0]   rem_in, cat, trial;
    logic [OW-1:0]   root_in;
    logic [IN_W-1:0] rad_in;
    logic            ge;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
    end

    assign cat   = {rem_in[RW-3:0], rad_in[IN_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = cat >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= ge ? cat - trial : cat;
      root_q[g] <= {root_in[OW-2:0], ge};
      rad_q[g]  <= rad_in << 2;
    end
  end

  assign root_o = root_q[OW-1];

endmodule

### design/vector_angle_3d.sv
// Angle between two 3D vectors: dot product, normalized lengths, divide, arc cosine.
// Depends on va3_pkg and va3_isqrt.
//
//  channel   ports                            handshake
//  request   a_x_i..b_z_i                     start & !busy
//  result    angle_o, degenerate_o            done_o, one cycle
//
// One request per cycle; busy stays low: nothing stalls.
// The path from start to done_o runs through the two 32/31-stage root pipelines,
// the 31-stage divider, the 31-stage CORDIC and the shorter stages between them.
// Reset clears the valid and side flags travelling with the data, and sq1_q/sq2_q.
module vector_angle_3d
  import va3_pkg::*;
#(
  parameter int unsigned COMPONENT_WIDTH     = COMP_W_DEF,
  parameter int unsigned ANGLE_FRACTION_BITS = ANGLE_FB_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COMPONENT_WIDTH-1:0]   a_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0]   a_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0]   a_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0]   b_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0]   b_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0]   b_z_i,
  output logic [ANGLE_FRACTION_BITS+1:0]      angle_o,
  output logic                                degenerate_o,
  output logic                                done_o
);

  localparam int unsigned CW      = COMPONENT_WIDTH;
  localparam int unsigned AFB     = ANGLE_FRACTION_BITS;
  localparam int unsigned AW      = AFB + 2;
  localparam int unsigned SQ1_LAT = NW / 2;
  localparam int unsigned SQ2_LAT = RADW / 2;
  localparam int unsigned DIV_STEPS = QW;
  localparam logic signed [CRW-1:0] RND = CRW'(64'd1 << (29 - AFB));
  localparam logic [CRW-1:0] ANGLE_MAX_W = CRW'((PI_Q30 + RND) >>> (30 - AFB));
  localparam logic [AW-1:0]  ANGLE_MAX = ANGLE_MAX_W[AW-1:0];

  typedef struct packed {
    side_t          sd;
    logic [5:0]     sst;
    logic [NW-1:0]  dm;
  } sq1_t;

  typedef struct packed {
    side_t          sd;
    logic [QW-1:0]  q;
  } sq2_t;

  assign busy = 1'b0;

  // stage 0: input registers
  logic                 v0_q;
  logic signed [CW-1:0] a0_q [3];
  logic signed [CW-1:0] b0_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    a0_q[0] <= a_x_i;
    a0_q[1] <= a_y_i;
    a0_q[2] <= a_z_i;
    b0_q[0] <= b_x_i;
    b0_q[1] <= b_y_i;
    b0_q[2] <= b_z_i;
  end

  // stage 1: component products
  logic [CW-1:0]   amag [3];
  logic [CW-1:0]   bmag [3];
  logic            v1_q;
  logic [2*CW-1:0] sqa1_q [3];
  logic [2*CW-1:0] sqb1_q [3];
  logic [2*CW-1:0] ab1_q  [3];
  logic [2:0]      sdif1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag[i] = a0_q[i][CW-1] ? CW'(-a0_q[i]) : CW'(a0_q[i]);
      bmag[i] = b0_q[i][CW-1] ? CW'(-b0_q[i]) : CW'(b0_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sqa1_q[i]  <= amag[i] * amag[i];
      sqb1_q[i]  <= bmag[i] * bmag[i];
      ab1_q[i]   <= amag[i] * bmag[i];
      sdif1_q[i] <= a0_q[i][CW-1] ^ b0_q[i][CW-1];
    end
  end

  // stage 2: sums
  logic          v2_q;
  logic [NW-1:0] na2_q, nb2_q, pos2_q, neg2_q;
  logic [NW-1:0] pos_d, neg_d;

  always_comb begin
    pos_d = '0;
    neg_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (sdif1_q[i]) begin
        neg_d = neg_d + NW'(ab1_q[i]);
      end else begin
        pos_d = pos_d + NW'(ab1_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    na2_q  <= NW'(sqa1_q[0]) + NW'(sqa1_q[1]) + NW'(sqa1_q[2]);
    nb2_q  <= NW'(sqb1_q[0]) + NW'(sqb1_q[1]) + NW'(sqb1_q[2]);
    pos2_q <= pos_d;
    neg2_q <= neg_d;
  end

  // stage 3: dot magnitude, zero check, normalize counts
  side_t          sd3_q;
  logic [NW-1:0]  dm3_q, na3_q, nb3_q;
  logic [LZW-1:0] s3_q, t3_q;
  logic           dneg_d;

  assign dneg_d = neg2_q > pos2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd3_q <= '0;
    end else begin
      sd3_q.vld  <= v2_q;
      sd3_q.deg  <= (na2_q == '0) || (nb2_q == '0);
      sd3_q.dneg <= dneg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dm3_q <= dneg_d ? neg2_q - pos2_q : pos2_q - neg2_q;
    na3_q <= na2_q;
    nb3_q <= nb2_q;
    s3_q  <= lz_pairs(na2_q);
    t3_q  <= lz_pairs(nb2_q);
  end

  // stage 4: normalize
  side_t         sd4_q;
  logic [NW-1:0] na4_q, nb4_q, dm4_q;
  logic [5:0]    sst4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd4_q <= '0;
    end else begin
      sd4_q <= sd3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    na4_q  <= na3_q << {s3_q, 1'b0};
    nb4_q  <= nb3_q << {t3_q, 1'b0};
    sst4_q <= 6'(s3_q) + 6'(t3_q);
    dm4_q  <= dm3_q;
  end

  // length roots
  logic [SQ1_LAT-1:0] la, lb;
  sq1_t               sq1_q [SQ1_LAT];

  va3_isqrt #(.IN_W(NW)) u_sqrt_a (.clk_i(clk_i), .rad_i(na4_q), .root_o(la));
  va3_isqrt #(.IN_W(NW)) u_sqrt_b (.clk_i(clk_i), .rad_i(nb4_q), .root_o(lb));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQ1_LAT; k++) sq1_q[k] <= '0;
    end else begin
      sq1_q[0] <= '{sd: sd4_q, sst: sst4_q, dm: dm4_q};
      for (int k = 1; k < SQ1_LAT; k++) sq1_q[k] <= sq1_q[k-1];
    end
  end

  // stage 5: length product, scaled numerator
  side_t         sd5_q;
  logic [NW-1:0] p5_q;
  logic [XW-1:0] x5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd5_q <= '0;
    end else begin
      sd5_q <= sq1_q[SQ1_LAT-1].sd;
    end
  end

  always_ff @(posedge clk_i) begin
    p5_q <= la * lb;
    x5_q <= XW'(sq1_q[SQ1_LAT-1].dm) << sq1_q[SQ1_LAT-1].sst;
  end

  // restoring divider, one quotient bit per stage
  logic [XW-1:0] drem_q [DIV_STEPS];
  logic [QW-1:0] dquo_q [DIV_STEPS];
  logic [NW-1:0] dp_q   [DIV_STEPS];
  side_t         dsd_q  [DIV_STEPS];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    logic [XW-1:0] num;
    logic [QW-1:0] quo_in;
    logic [NW-1:0] den;
    side_t         sd_in;
    logic          ge;

    if (g == 0) begin : g_first
      assign num    = x5_q;
      assign quo_in = '0;
      assign den    = p5_q;
      assign sd_in  = sd5_q;
    end else begin : g_next
      assign num    = {drem_q[g-1][XW-2:0], 1'b0};
      assign quo_in = dquo_q[g-1];
      assign den    = dp_q[g-1];
      assign sd_in  = dsd_q[g-1];
    end

    assign ge = num >= XW'(den);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dsd_q[g] <= '0;
      end else begin
        dsd_q[g] <= sd_in;
      end
    end

    always_ff @(posedge clk_i) begin
      drem_q[g] <= ge ? num - XW'(den) : num;
      dquo_q[g] <= {quo_in[QW-2:0], ge};
      dp_q[g]   <= den;
    end
  end

  // stages 6..8: saturate, square, sine radicand
  side_t           sd6_q, sd7_q, sd8_q;
  logic [QW-1:0]   q6_q, q7_q, q8_q;
  logic [RADW-1:0] sq7_q, rad8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd6_q <= '0;
      sd7_q <= '0;
      sd8_q <= '0;
    end else begin
      sd6_q <= dsd_q[DIV_STEPS-1];
      sd7_q <= sd6_q;
      sd8_q <= sd7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q6_q   <= (dquo_q[DIV_STEPS-1] > Q30_ONE) ? Q30_ONE : dquo_q[DIV_STEPS-1];
    sq7_q  <= q6_q * q6_q;
    q7_q   <= q6_q;
    rad8_q <= Q60_ONE - sq7_q;
    q8_q   <= q7_q;
  end

  // sine root
  logic [SQ2_LAT-1:0] sn;
  sq2_t               sq2_q [SQ2_LAT];

  va3_isqrt #(.IN_W(RADW)) u_sqrt_s (.clk_i(clk_i), .rad_i(rad8_q), .root_o(sn));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQ2_LAT; k++) sq2_q[k] <= '0;
    end else begin
      sq2_q[0] <= '{sd: sd8_q, q: q8_q};
      for (int k = 1; k < SQ2_LAT; k++) sq2_q[k] <= sq2_q[k-1];
    end
  end

  // vectoring CORDIC: atan2(sine, cosine)
  logic                  c_neg;
  logic signed [CRW-1:0] cx0, cy0, cz0;
  logic signed [CRW-1:0] cx_q [CORDIC_STEPS];
  logic signed [CRW-1:0] cy_q [CORDIC_STEPS];
  logic signed [CRW-1:0] cz_q [CORDIC_STEPS];
  side_t                 csd_q [CORDIC_STEPS];

  always_comb begin
    c_neg = sq2_q[SQ2_LAT-1].sd.dneg && (sq2_q[SQ2_LAT-1].q != '0);
    if (c_neg) begin
      cx0 = $signed({3'b000, sn});
      cy0 = $signed({3'b000, sq2_q[SQ2_LAT-1].q});
      cz0 = HALF_PI_Q30;
    end else begin
      cx0 = $signed({3'b000, sq2_q[SQ2_LAT-1].q});
      cy0 = $signed({3'b000, sn});
      cz0 = '0;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    logic signed [CRW-1:0] x_in, y_in, z_in, xs, ys;
    side_t                 sd_in;
    logic                  up;

    if (g == 0) begin : g_first
      assign x_in  = cx0;
      assign y_in  = cy0;
      assign z_in  = cz0;
      assign sd_in = sq2_q[SQ2_LAT-1].sd;
    end else begin : g_next
      assign x_in  = cx_q[g-1];
      assign y_in  = cy_q[g-1];
      assign z_in  = cz_q[g-1];
      assign sd_in = csd_q[g-1];
    end

    assign xs = x_in >>> g;
    assign ys = y_in >>> g;
    assign up = !y_in[CRW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        csd_q[g] <= '0;
      end else begin
        csd_q[g] <= sd_in;
      end
    end

    always_ff @(posedge clk_i) begin
      cx_q[g] <= up ? x_in + ys : x_in - ys;
      cy_q[g] <= up ? y_in - xs : y_in + xs;
      cz_q[g] <= up ? z_in + atan_q30(g) : z_in - atan_q30(g);
    end
  end

  // output: clamp, round
  logic signed [CRW-1:0] zc, zr;
  logic [AW-1:0]         angle_d, angle_q;
  logic                  deg_q, done_q;

  always_comb begin
    zc = cz_q[CORDIC_STEPS-1];
    if (zc[CRW-1]) begin
      zc = '0;
    end else if (zc > PI_Q30) begin
      zc = PI_Q30;
    end
    zr      = zc + RND;
    angle_d = csd_q[CORDIC_STEPS-1].deg ? '0 : zr[30-AFB +: AW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= csd_q[CORDIC_STEPS-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
    deg_q   <= csd_q[CORDIC_STEPS-1].deg;
  end

  assign angle_o      = angle_q;
  assign degenerate_o = deg_q;
  assign done_o       = done_q;

`ifndef ASSERT_OFF
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> angle_o == '0)
    else $error("degenerate result with nonzero angle");

  a_angle_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> angle_o <= ANGLE_MAX)
    else $error("angle above pi");

  a_len_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq1_q[SQ1_LAT-1].sd.vld && !sq1_q[SQ1_LAT-1].sd.deg |->
      la[SQ1_LAT-1] && lb[SQ1_LAT-1])
    else $error("length root not normalized");

  a_div_int: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dsd_q[0].vld && !dsd_q[0].deg |-> drem_q[0] < XW'(dp_q[0]))
    else $error("cosine numerator at or above twice the length product");
`endif

endmodule

### bench/tb_vector_angle_3d.sv
// Self-checking bench for vector_angle_3d: random and directed vector pairs,
// predicted angles compared against the result strobe. Depends on va3_pkg.
module tb_vector_angle_3d;
  timeunit 1ns;
  timeprecision 1ps;
  import va3_pkg::*;

  localparam int unsigned CW  = COMP_W_DEF;
  localparam int unsigned AFB = ANGLE_FB_DEF;
  localparam int unsigned AW  = AFB + 2;
  localparam int unsigned N_ITEMS = 1950;
  localparam int unsigned LAT = 135;

  typedef struct {
    logic [AW-1:0] angle;
    logic          deg;
  } angle_t;

  class angle_board;
    angle_t angle_due[$];
    int     errors = 0;

    static function longint unsigned root64(longint unsigned n);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
        if (n >= res + bit_v) begin
          n -= res + bit_v;
          res = (res >> 1) + bit_v;
        end else begin
          res >>= 1;
        end
        bit_v >>= 2;
      end
      return res;
    endfunction

    static function longint unsigned norm_len(longint unsigned n, output int unsigned sh);
      sh = 0;
      while (n < (64'd1 << 62)) begin
        n <<= 2;
        sh++;
      end
      return root64(n);
    endfunction

    static function angle_t angle_of(logic signed [CW-1:0] av[3], logic signed [CW-1:0] bv[3]);
      angle_t          o;
      longint unsigned na, nb, pos, neg, dm, p, q, r, sn, ma, mb, one, hi;
      longint          c, x, y, z, xs, ys, tv;
      int unsigned     s, t, e, k;
      logic            dneg;
      na = 0; nb = 0; pos = 0; neg = 0;
      one = 64'd1 << 30;
      for (int i = 0; i < 3; i++) begin
        ma = av[i] < 0 ? longint'(-longint'(av[i])) : longint'(av[i]);
        mb = bv[i] < 0 ? longint'(-longint'(bv[i])) : longint'(bv[i]);
        na += ma * ma;
        nb += mb * mb;
        if ((av[i] < 0) != (bv[i] < 0)) neg += ma * mb;
        else pos += ma * mb;
      end
      if (na == 0 || nb == 0) begin
        o.angle = '0;
        o.deg = 1'b1;
        return o;
      end
      dneg = neg > pos;
      dm = dneg ? neg - pos : pos - neg;
      p = norm_len(na, s);
      p = p * norm_len(nb, t);
      e = s + t + 30;
      q = dm / p;
      r = dm % p;
      for (k = 0; k < e && q <= one; k++) begin
        hi = r >> 63;
        r <<= 1;
        q <<= 1;
        if (hi != 0 || r >= p) begin
          r -= p;
          q++;
        end
      end
      if (q > one) q = one;
      c = dneg ? -longint'(q) : longint'(q);
      sn = root64((one << 30) - q * q);
      if (c < 0) begin
        x = longint'(sn); y = -c; z = longint'(HALF_PI_Q30);
      end else begin
        x = c; y = longint'(sn); z = 0;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        tv = longint'(atan_tab(i));
        if (y >= 0) begin
          x += ys; y -= xs; z += tv;
        end else begin
          x -= ys; y += xs; z -= tv;
        end
      end
      if (z < 0) z = 0;
      if (z > longint'(PI_Q30)) z = longint'(PI_Q30);
      o.angle = AW'((longint'(z) + (64'd1 << (29 - AFB))) >> (30 - AFB));
      o.deg = 1'b0;
      return o;
    endfunction

    static function longint atan_tab(int i);
      longint tab[31] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
        'h00000001};
      return tab[i];
    endfunction

    function void note_request(logic signed [CW-1:0] av[3], logic signed [CW-1:0] bv[3]);
      angle_due.push_back(angle_of(av, bv));
    endfunction

    function void check_angle(logic [AW-1:0] angle, logic deg);
      angle_t want;
      if (angle_due.size() == 0) begin
        $display("%0t: unexpected result angle=%0d degenerate=%0b", $time, angle, deg);
        errors++;
        return;
      end
      want = angle_due.pop_front();
      if (angle !== want.angle) begin
        $display("%0t: angle expected %0d actual %0d", $time, want.angle, angle);
        errors++;
      end
      if (deg !== want.deg) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, want.deg, deg);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] a_x_i = '0, a_y_i = '0, a_z_i = '0;
  logic signed [CW-1:0] b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic [AW-1:0] angle_o;
  logic          degenerate_o;
  logic          done_o;

  angle_board board = new();
  int unsigned idle_pct = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  vector_angle_3d dut (
    .clk_i, .rst_ni, .start, .busy,
    .a_x_i, .a_y_i, .a_z_i, .b_x_i, .b_y_i, .b_z_i,
    .angle_o, .degenerate_o, .done_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      board.note_request('{a_x_i, a_y_i, a_z_i}, '{b_x_i, b_y_i, b_z_i});
    if (rst_ni && done_o) board.check_angle(angle_o, degenerate_o);
  end

  // start is left high on return; the next request or an idle cycle replaces it
  task automatic send_request(logic signed [CW-1:0] av[3], logic signed [CW-1:0] bv[3]);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    a_x_i <= av[0]; a_y_i <= av[1]; a_z_i <= av[2];
    b_x_i <= bv[0]; b_y_i <= bv[1]; b_z_i <= bv[2];
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic signed [CW-1:0] rnd_comp();
    case ($urandom_range(3))
      0:       return CW'($urandom_range(15)) - CW'(8);
      1:       return $urandom_range(1) ? 16'sh7fff - CW'($urandom_range(3))
                                        : 16'sh8000 + CW'($urandom_range(3));
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic random_request();
    logic signed [CW-1:0] av[3], bv[3];
    int m;
    for (int i = 0; i < 3; i++) begin
      av[i] = rnd_comp();
      bv[i] = rnd_comp();
    end
    case ($urandom_range(9))
      0: av = '{0, 0, 0};
      1: bv = '{0, 0, 0};
      2, 3: begin
        m = $urandom_range(1) ? 1 : -1;
        for (int i = 0; i < 3; i++) begin
          av[i] = CW'($urandom_range(4095)) - CW'(2048);
          bv[i] = CW'(m * av[i] * 7 + int'($urandom_range(2)) - 1);
        end
      end
      default: ;
    endcase
    send_request(av, bv);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_request('{16'sh8000, 16'sh8000, 16'sh8000}, '{16'sh8000, 16'sh8000, 16'sh8000});
    send_request('{16'sh7fff, 16'sh7fff, 16'sh7fff}, '{16'sh8000, 16'sh8000, 16'sh8000});
    send_request('{16'sh7fff, 16'sh8000, 16'sh7fff}, '{16'sh8000, 16'sh7fff, 16'sh0001});
    send_request('{0, 0, 0}, '{1, 2, 3});
    send_request('{5, -6, 7}, '{0, 0, 0});
    send_request('{0, 0, 0}, '{0, 0, 0});
    send_request('{1, 0, 0}, '{0, 1, 0});
    send_request('{0, 0, -1}, '{0, 0, 1});
    send_request('{1, 0, 0}, '{1, 0, 0});
    send_request('{3, 3, 3}, '{1, 1, 1});
    send_request('{-3, -3, -3}, '{1, 1, 1});
    send_request('{1, 1, 1}, '{16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_request('{1, 1, 0}, '{1, 0, 0});
    send_request('{-1, 1, 0}, '{1, 0, 0});
    send_request('{16'sh7fff, 0, 0}, '{16'sh7fff, 1, 0});
    send_request('{16'sh8000, 0, 0}, '{16'sh7fff, 0, 1});
    send_request('{16'sh5555, 16'shaaaa, 16'sh0f0f}, '{16'shf0f0, 16'sh3333, 16'shcccc});
    idle_pct = 34;
    for (int n = 0; n < N_ITEMS / 3; n++) random_request();
    idle_pct = 77;
    for (int n = 0; n < N_ITEMS / 3; n++) random_request();
    idle_pct = 0;
    for (int n = 0; n < N_ITEMS / 3; n++) random_request();
    start <= 1'b0;
    while (board.angle_due.size() != 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
    if (board.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
